// ===== rtl/lufb_pkg.sv =====
// Shared types, constants and AES-128 helper functions for the uplink frame builder.
package lufb_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int KS_BLOCKS = (MAX_PAYLOAD + 15) / 16;
  localparam int KS_W = 128 * KS_BLOCKS;
  localparam int CTR_W = $clog2(KS_BLOCKS + 1);
  localparam int HDR_BYTES = 9;
  localparam int POS_W = $clog2(16 + HDR_BYTES + MAX_PAYLOAD + 16 + 1);

  localparam logic [7:0] MHDR_UNCONF_UP = 8'h40;
  localparam logic [7:0] B0_TAG = 8'h49;
  localparam logic [7:0] A_TAG = 8'h01;
  localparam logic [7:0] CMAC_PAD = 8'h80;
  localparam logic [127:0] CMAC_RB = 128'h87;

  localparam logic [2:0] CFG_DEV_ADDRESS = 3'd0;
  localparam logic [2:0] CFG_NWK_HIGH = 3'd1;
  localparam logic [2:0] CFG_NWK_LOW = 3'd2;
  localparam logic [2:0] CFG_APP_HIGH = 3'd3;
  localparam logic [2:0] CFG_APP_LOW = 3'd4;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic [7:0]       port;
    logic [31:0]      fcnt;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } pay_rd_t;

  typedef struct packed {
    logic         start;
    logic [127:0] key;
    logic [127:0] blk;
  } aes_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round without the round key; byte 0 sits in the top bits.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = SBOX[s[127-8*((((c+i)%4)*4)+i) -: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ all ^ xt(a0 ^ a1);
        t[c*4+1] = a1 ^ all ^ xt(a1 ^ a2);
        t[c*4+2] = a2 ^ all ^ xt(a2 ^ a3);
        t[c*4+3] = a3 ^ all ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i];
    end
    return r;
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? CMAC_RB : 128'h0);
  endfunction

endpackage

// ===== rtl/lufb_jobq.sv =====
// Two-entry queue of frame jobs between the front end and the frame engine.
module lufb_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lufb_pkg::job_t push_job,
  input  logic          pop,
  output lufb_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import lufb_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign head = slot_r[rd_ptr_r];
  assign full = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

// ===== rtl/lufb_front.sv =====
// Input front end: collects payload words into the payload memory and queues frame jobs.
module lufb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,
  input  logic              in_tuser,
  input  logic              in_tlast,
  output logic              job_push,
  output lufb_pkg::job_t    job_out,
  input  logic              job_full,
  input  logic              frame_done,
  input  lufb_pkg::pay_rd_t pay_rd,
  output logic [7:0]        pay_data
);
  import lufb_pkg::*;

  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       rd_data_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             hold_r;
  logic             acc, room;

  assign in_tready = !hold_r && !job_full;
  assign acc = in_tvalid && in_tready;
  assign room = (len_r < LEN_W'(MAX_PAYLOAD));
  assign pay_data = rd_data_r;

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (in_tuser) begin
      if (room) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  assign job_push = acc && in_tlast;
  assign job_out = '{len: len_nxt, ovf: ovf_nxt, port: in_tdata[15:8], fcnt: in_tdata[47:16]};

  always_ff @(posedge clk) begin
    if (acc && in_tuser && room) begin
      mem[len_r[ADDR_W-1:0]] <= in_tdata[7:0];
    end
    if (pay_rd.en) begin
      rd_data_r <= mem[pay_rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      hold_r <= 1'b0;
    end else begin
      if (acc) begin
        if (in_tlast) begin
          len_r <= '0;
          ovf_r <= 1'b0;
          hold_r <= 1'b1;
        end else begin
          len_r <= len_nxt;
          ovf_r <= ovf_nxt;
        end
      end else if (frame_done) begin
        hold_r <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/lufb_aes.sv =====
// Iterative AES-128 encryption core, one round per cycle with on-the-fly key expansion.
module lufb_aes (
  input  logic               clk,
  input  logic               rst_n,
  input  lufb_pkg::aes_req_t req,
  output logic               done,
  output logic [127:0]       result
);
  import lufb_pkg::*;

  logic [127:0] state_r, rk_r, rk_nxt;
  logic [7:0]   rcon_r;
  logic [3:0]   round_r;
  logic         busy_r, done_r;

  assign rk_nxt = key_step(rk_r, rcon_r);
  assign done = done_r;
  assign result = state_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      state_r <= req.blk ^ req.key;
      rk_r <= req.key;
      rcon_r <= 8'h01;
      round_r <= 4'd1;
    end else if (busy_r) begin
      state_r <= aes_round(state_r, round_r == 4'd10) ^ rk_nxt;
      rk_r <= rk_nxt;
      rcon_r <= xt(rcon_r);
      round_r <= round_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && round_r == 4'd10) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end
endmodule

// ===== rtl/lufb_back.sv =====
// Frame engine: counter-mode encryption, CMAC over the frame and byte-wise frame output.
module lufb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  lufb_pkg::job_t    job_head,
  input  logic              job_empty,
  output logic              job_pop,
  output lufb_pkg::pay_rd_t pay_rd,
  input  logic [7:0]        pay_data,
  output logic              frame_done,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);
  import lufb_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CTR_GO   = 4'd1;
  localparam logic [3:0] S_CTR_WAIT = 4'd2;
  localparam logic [3:0] S_L_GO     = 4'd3;
  localparam logic [3:0] S_L_WAIT   = 4'd4;
  localparam logic [3:0] S_BLK_ADDR = 4'd5;
  localparam logic [3:0] S_BLK_DATA = 4'd6;
  localparam logic [3:0] S_MAC_GO   = 4'd7;
  localparam logic [3:0] S_MAC_WAIT = 4'd8;
  localparam logic [3:0] S_OUT_ADDR = 4'd9;
  localparam logic [3:0] S_OUT_DATA = 4'd10;
  localparam logic [3:0] S_OUT_HOLD = 4'd11;

  logic [31:0]      devaddr_r;
  logic [63:0]      nwk_hi_r, nwk_lo_r, app_hi_r, app_lo_r;
  logic [3:0]       state_r;
  logic [LEN_W-1:0] len_r;
  logic             ovf_r;
  logic [7:0]       port_r;
  logic [31:0]      fcnt_r;
  logic [KS_W-1:0]  ks_r;
  logic [CTR_W-1:0] ctr_r;
  logic [127:0]     k1_r, k2_r, x_r, blk_r;
  logic [POS_W-1:0] pos_r, idx_r;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_byte_r;

  logic [LEN_W:0]   nblk;
  logic [POS_W-1:0] mlen, mtot, msg_k, pay_q;
  logic [7:0]       mbyte, gbyte, tbyte;
  logic [127:0]     b0_blk, ai_blk, gblk, k1_new;
  logic [31:0]      da_le, fc_le;
  aes_req_t         aes_req;
  logic             aes_done;
  logic [127:0]     aes_res;

  lufb_aes u_aes (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (aes_req),
    .done  (aes_done),
    .result(aes_res)
  );

  assign cfg_ready = 1'b1;
  assign nblk = ({1'b0, len_r} + (LEN_W+1)'(15)) >> 4;
  assign mlen = POS_W'(HDR_BYTES) + POS_W'(len_r);
  assign mtot = POS_W'(16) + mlen;
  assign da_le = {devaddr_r[7:0], devaddr_r[15:8], devaddr_r[23:16], devaddr_r[31:24]};
  assign fc_le = {fcnt_r[7:0], fcnt_r[15:8], fcnt_r[23:16], fcnt_r[31:24]};
  assign b0_blk = {B0_TAG, 32'h0, 8'h0, da_le, fc_le, 8'h0, 8'(mlen)};
  assign ai_blk = {A_TAG, 32'h0, 8'h0, da_le, fc_le, 8'h0, 8'(ctr_r) + 8'd1};
  assign msg_k = (state_r == S_BLK_ADDR || state_r == S_BLK_DATA) ? pos_r - POS_W'(16) : idx_r;
  assign pay_q = msg_k - POS_W'(HDR_BYTES);
  assign pay_rd = '{en: (state_r == S_BLK_ADDR || state_r == S_OUT_ADDR),
                    addr: pay_q[ADDR_W-1:0]};
  assign k1_new = dbl(aes_res);

  always_comb begin
    unique case (msg_k)
      POS_W'(0): mbyte = MHDR_UNCONF_UP;
      POS_W'(1): mbyte = devaddr_r[7:0];
      POS_W'(2): mbyte = devaddr_r[15:8];
      POS_W'(3): mbyte = devaddr_r[23:16];
      POS_W'(4): mbyte = devaddr_r[31:24];
      POS_W'(5): mbyte = 8'h00;
      POS_W'(6): mbyte = fcnt_r[7:0];
      POS_W'(7): mbyte = fcnt_r[15:8];
      POS_W'(8): mbyte = port_r;
      default:   mbyte = pay_data ^ ks_r[KS_W-1-8*pay_q[ADDR_W-1:0] -: 8];
    endcase
  end

  always_comb begin
    if (pos_r < mtot) begin
      gbyte = mbyte;
    end else if (pos_r == mtot) begin
      gbyte = CMAC_PAD;
    end else begin
      gbyte = 8'h00;
    end
    gblk = {blk_r[119:0], gbyte};
    if ((pos_r[3:0] == 4'd15) && (pos_r + POS_W'(1) >= mtot)) begin
      gblk = gblk ^ ((mtot[3:0] == 4'd0) ? k1_r : k2_r);
    end
    tbyte = x_r[127-8*(2'(idx_r - mlen)) -: 8];
  end

  always_comb begin
    aes_req.start = 1'b0;
    aes_req.key = {nwk_hi_r, nwk_lo_r};
    aes_req.blk = x_r ^ blk_r;
    unique case (state_r)
      S_CTR_GO: begin
        aes_req.start = ((LEN_W+1)'(ctr_r) != nblk);
        aes_req.key = {app_hi_r, app_lo_r};
        aes_req.blk = ai_blk;
      end
      S_L_GO: begin
        aes_req.start = 1'b1;
        aes_req.blk = 128'h0;
      end
      S_MAC_GO: aes_req.start = 1'b1;
      default: aes_req.start = 1'b0;
    endcase
  end

  assign job_pop = (state_r == S_IDLE) && !job_empty;
  assign frame_done = (state_r == S_OUT_HOLD) && out_tready && out_last_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_byte_r;
  assign out_tlast = out_last_r;
  assign out_tuser = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      devaddr_r <= '0;
      nwk_hi_r <= '0;
      nwk_lo_r <= '0;
      app_hi_r <= '0;
      app_lo_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEV_ADDRESS: devaddr_r <= cfg_data[31:0];
        CFG_NWK_HIGH:    nwk_hi_r <= cfg_data;
        CFG_NWK_LOW:     nwk_lo_r <= cfg_data;
        CFG_APP_HIGH:    app_hi_r <= cfg_data;
        CFG_APP_LOW:     app_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        len_r <= job_head.len;
        ovf_r <= job_head.ovf;
        port_r <= job_head.port;
        fcnt_r <= job_head.fcnt;
        ctr_r <= '0;
      end
      S_CTR_WAIT: begin
        if (aes_done) begin
          ks_r[KS_W-1-128*ctr_r -: 128] <= aes_res;
          ctr_r <= ctr_r + CTR_W'(1);
        end
      end
      S_L_WAIT: begin
        k1_r <= k1_new;
        k2_r <= dbl(k1_new);
        x_r <= '0;
        blk_r <= b0_blk;
        pos_r <= POS_W'(16);
        idx_r <= '0;
      end
      S_BLK_DATA: begin
        blk_r <= gblk;
        pos_r <= pos_r + POS_W'(1);
      end
      S_MAC_WAIT: begin
        if (aes_done) begin
          x_r <= aes_res;
        end
      end
      S_OUT_DATA: begin
        out_byte_r <= (idx_r < mlen) ? mbyte : tbyte;
        out_last_r <= (idx_r == mlen + POS_W'(3));
      end
      S_OUT_HOLD: begin
        if (out_tready) begin
          idx_r <= idx_r + POS_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE:     if (!job_empty) state_r <= S_CTR_GO;
        S_CTR_GO:   state_r <= aes_req.start ? S_CTR_WAIT : S_L_GO;
        S_CTR_WAIT: if (aes_done) state_r <= S_CTR_GO;
        S_L_GO:     state_r <= S_L_WAIT;
        S_L_WAIT:   if (aes_done) state_r <= S_MAC_GO;
        S_BLK_ADDR: state_r <= S_BLK_DATA;
        S_BLK_DATA: state_r <= (pos_r[3:0] == 4'd15) ? S_MAC_GO : S_BLK_ADDR;
        S_MAC_GO:   state_r <= S_MAC_WAIT;
        S_MAC_WAIT: begin
          if (aes_done) begin
            state_r <= (pos_r >= mtot) ? S_OUT_ADDR : S_BLK_ADDR;
          end
        end
        S_OUT_ADDR: state_r <= S_OUT_DATA;
        S_OUT_DATA: begin
          out_valid_r <= 1'b1;
          state_r <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r <= out_last_r ? S_IDLE : S_OUT_ADDR;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/lorawan_uplink_frame_builder.sv =====
// Top level of the LoRaWAN unconfirmed-data-up frame builder.
// Payload words are taken one per cycle and stored until the word with tlast; the input
// then stalls until the last byte of that frame has left. Once the frame engine takes the
// job it loads it, ciphers the counter-mode keystream blocks, closes the counter phase,
// ciphers the zero block for the CMAC subkeys, then B0, and then each further CMAC block
// after gathering its bytes one at a time, and finally sends each frame byte while the
// sink is ready. The pace of these steps follows from the single iterative AES core
// doing one round per cycle and the one registered read port of the payload memory.
module lorawan_uplink_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // payload_byte, port_number, frame_count
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // frame_byte
  output logic        out_tuser,  // payload_overflow
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import lufb_pkg::*;

  job_t    push_job, head_job;
  logic    job_push, job_pop, job_full, job_empty, frame_done;
  pay_rd_t pay_rd;
  logic [7:0] pay_data;

  lufb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .job_push  (job_push),
    .job_out   (push_job),
    .job_full  (job_full),
    .frame_done(frame_done),
    .pay_rd    (pay_rd),
    .pay_data  (pay_data)
  );

  lufb_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .push_job(push_job),
    .pop     (job_pop),
    .head    (head_job),
    .full    (job_full),
    .empty   (job_empty)
  );

  lufb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_head  (head_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .pay_rd    (pay_rd),
    .pay_data  (pay_data),
    .frame_done(frame_done),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );
endmodule
